>>> sv/vnl_pkg.sv
// shared types, constants and codes for the verilog number literal parser
`default_nettype none

package vnl_pkg;

    localparam int unsigned VALUE_W       = 64;
    localparam int unsigned WIDTH_W       = 32;
    localparam int unsigned CHAR_W        = 8;
    localparam int unsigned DIGIT_W       = 4;
    localparam int unsigned QUEUE_DEPTH   = 2;
    localparam int unsigned QUEUE_PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WIDTH_W-1:0] DEFAULT_WIDTH = WIDTH_W'(32);

    localparam logic [CHAR_W-1:0] CH_TICK  = 8'h27;
    localparam logic [CHAR_W-1:0] CH_SKIP  = 8'h5f;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LO_H  = 8'h68;
    localparam logic [CHAR_W-1:0] CH_UP_H  = 8'h48;
    localparam logic [CHAR_W-1:0] CH_LO_B  = 8'h62;
    localparam logic [CHAR_W-1:0] CH_UP_B  = 8'h42;
    localparam logic [CHAR_W-1:0] CH_LO_O  = 8'h6f;
    localparam logic [CHAR_W-1:0] CH_UP_O  = 8'h4f;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_HEX = 2'd1,
        RX_BIN = 2'd2,
        RX_OCT = 2'd3
    } t_radix;

    typedef enum logic [1:0] {
        ST_FIRST   = 2'd0,
        ST_DIGITS  = 2'd1,
        ST_STOPPED = 2'd2,
        ST_BAD     = 2'd3
    } t_status;

    typedef struct packed {
        logic                has_char;
        logic                last;
        logic                is_hex;
        logic [DIGIT_W-1:0]  digit;
        logic                is_tick;
        logic                is_skip;
        t_radix              base;
    } t_item;

endpackage

`default_nettype wire

>>> sv/verilog_number_literal_parser.sv
// top level: number literal parser taking one character per transaction
// throughput: one character per cycle, sustained, under no backpressure
// result: the transaction carrying last is written into the two-entry queue between
// classifier and accumulator, and o_out_valid is registered when the back end pops it
// reset: synchronous active-low i_rst_n empties the queue, clears parser state
// and drops any pending result
`default_nettype none

module verilog_number_literal_parser
    import vnl_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [CHAR_W-1:0]   i_character,
    input  wire logic                i_has_char,
    input  wire logic                i_last,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic                     o_ok,
    output logic [VALUE_W-1:0]       o_value,
    output logic [WIDTH_W-1:0]       o_width
);

    t_item  front_item;
    t_item  q_item;
    logic   q_valid;
    logic   back_ready;

    vnl_front u_front (
        .i_character (i_character),
        .i_has_char  (i_has_char),
        .i_last      (i_last),
        .o_item      (front_item)
    );

    vnl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (front_item),
        .o_ready (o_in_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_ready (back_ready)
    );

    vnl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_ready     (back_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ok        (o_ok),
        .o_value     (o_value),
        .o_width     (o_width)
    );

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> (o_value == '0 && o_width == '0))
        else $error("failed result carries nonzero value or width");

    a_full_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> q_valid)
        else $error("queue refuses input while empty");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending right after reset");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid && !q_valid) |=> !o_out_valid)
        else $error("result appeared without a queued transaction");

endmodule

`default_nettype wire

>>> sv/vnl_front.sv
// front end: classifies each incoming character into digit, tick, skip and base codes
`default_nettype none

module vnl_front
    import vnl_pkg::*;
(
    input  wire logic [CHAR_W-1:0] i_character,
    input  wire logic              i_has_char,
    input  wire logic              i_last,
    output t_item                  o_item
);

    always_comb begin
        o_item          = '0;
        o_item.has_char = i_has_char;
        o_item.last     = i_last;
        o_item.is_tick  = (i_character == CH_TICK);
        o_item.is_skip  = (i_character == CH_SKIP);
        if (i_character >= CH_0 && i_character <= CH_9) begin
            o_item.is_hex = 1'b1;
            o_item.digit  = DIGIT_W'(i_character - CH_0);
        end else if (i_character >= CH_LO_A && i_character <= CH_LO_F) begin
            o_item.is_hex = 1'b1;
            o_item.digit  = DIGIT_W'(i_character - CH_LO_A + 8'd10);
        end else if (i_character >= CH_UP_A && i_character <= CH_UP_F) begin
            o_item.is_hex = 1'b1;
            o_item.digit  = DIGIT_W'(i_character - CH_UP_A + 8'd10);
        end
        if (i_character == CH_LO_H || i_character == CH_UP_H) begin
            o_item.base = RX_HEX;
        end else if (i_character == CH_LO_B || i_character == CH_UP_B) begin
            o_item.base = RX_BIN;
        end else if (i_character == CH_LO_O || i_character == CH_UP_O) begin
            o_item.base = RX_OCT;
        end else begin
            o_item.base = RX_DEC;
        end
    end

endmodule

`default_nettype wire

>>> sv/vnl_queue.sv
// short queue of classified characters between front and back end
`default_nettype none

module vnl_queue
    import vnl_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    output logic       o_ready,
    output logic       o_valid,
    output t_item      o_item,
    input  wire logic  i_ready
);

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   push;
    logic                   pop;

    assign o_ready = (r_count != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/vnl_back.sv
// back end: width and value accumulators, phase tracking and result register
`default_nettype none

module vnl_back
    import vnl_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire t_item               i_item,
    output logic                     o_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic                     o_ok,
    output logic [VALUE_W-1:0]       o_value,
    output logic [WIDTH_W-1:0]       o_width
);

    typedef enum logic [1:0] {
        PH_BEFORE = 2'd0,
        PH_BASE   = 2'd1,
        PH_VALUE  = 2'd2
    } t_phase;

    t_phase               r_phase;
    t_radix               r_radix;
    logic [WIDTH_W-1:0]   r_wacc;
    t_status              r_wst;
    logic [VALUE_W-1:0]   r_vacc;
    t_status              r_vst;

    t_phase               n_phase;
    t_radix               n_radix;
    logic [WIDTH_W-1:0]   n_wacc;
    t_status              n_wst;
    logic [VALUE_W-1:0]   n_vacc;
    t_status              n_vst;

    logic                 dig_ok;
    logic                 dec_ok;
    logic [VALUE_W+3:0]   v_scaled;
    logic [VALUE_W+3:0]   v_sum;
    logic [WIDTH_W+3:0]   w_sum;
    logic [VALUE_W-1:0]   v_acc;
    t_status              v_st;
    logic [WIDTH_W-1:0]   w_acc;
    t_status              w_st;
    logic                 res_ok;
    logic [WIDTH_W-1:0]   res_width;
    logic                 out_free;
    logic                 pop;

    assign out_free = !o_out_valid || i_out_ready;
    assign o_ready  = !i_item.last || out_free;
    assign pop      = i_valid && o_ready;

    always_comb begin
        unique case (r_radix)
            RX_DEC: dig_ok = i_item.is_hex && (i_item.digit < DIGIT_W'(10));
            RX_HEX: dig_ok = i_item.is_hex;
            RX_BIN: dig_ok = i_item.is_hex && (i_item.digit < DIGIT_W'(2));
            RX_OCT: dig_ok = i_item.is_hex && (i_item.digit < DIGIT_W'(8));
            default: dig_ok = 1'b0;
        endcase
        unique case (r_radix)
            RX_DEC: v_scaled = {1'b0, r_vacc, 3'b000} + {3'b000, r_vacc, 1'b0};
            RX_HEX: v_scaled = {r_vacc, 4'b0000};
            RX_BIN: v_scaled = {3'b000, r_vacc, 1'b0};
            RX_OCT: v_scaled = {1'b0, r_vacc, 3'b000};
            default: v_scaled = '0;
        endcase
    end

    assign v_sum  = v_scaled + {{VALUE_W{1'b0}}, i_item.digit};
    assign dec_ok = i_item.is_hex && (i_item.digit < DIGIT_W'(10));
    assign w_sum  = {1'b0, r_wacc, 3'b000} + {3'b000, r_wacc, 1'b0}
                  + {{WIDTH_W{1'b0}}, i_item.digit};

    // value digit step
    always_comb begin
        v_acc = r_vacc;
        v_st  = r_vst;
        if (!i_item.is_skip && (r_vst == ST_FIRST || r_vst == ST_DIGITS)) begin
            if (r_radix == RX_BIN) begin
                if (!dig_ok) begin
                    v_st = ST_BAD;
                end else begin
                    v_acc = v_sum[VALUE_W-1:0];
                    v_st  = ST_DIGITS;
                end
            end else if (!dig_ok) begin
                v_st = (r_vst == ST_FIRST) ? ST_BAD : ST_STOPPED;
            end else if (v_sum[VALUE_W+3:VALUE_W] != '0) begin
                v_st = ST_BAD;
            end else begin
                v_acc = v_sum[VALUE_W-1:0];
                v_st  = ST_DIGITS;
            end
        end
    end

    // width digit step
    always_comb begin
        w_acc = r_wacc;
        w_st  = r_wst;
        if (r_wst == ST_FIRST || r_wst == ST_DIGITS) begin
            if (!dec_ok) begin
                w_st = (r_wst == ST_FIRST) ? ST_BAD : ST_STOPPED;
            end else if (w_sum[WIDTH_W+3:WIDTH_W] != '0) begin
                w_st = ST_BAD;
            end else begin
                w_acc = w_sum[WIDTH_W-1:0];
                w_st  = ST_DIGITS;
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_radix = r_radix;
        n_wacc  = r_wacc;
        n_wst   = r_wst;
        n_vacc  = r_vacc;
        n_vst   = r_vst;
        if (i_item.has_char) begin
            unique case (r_phase)
                PH_BEFORE: begin
                    if (i_item.is_tick) begin
                        n_phase = PH_BASE;
                    end else begin
                        n_wacc = w_acc;
                        n_wst  = w_st;
                        n_vacc = v_acc;
                        n_vst  = v_st;
                    end
                end
                PH_BASE: begin
                    n_radix = i_item.base;
                    n_vacc  = '0;
                    n_vst   = ST_FIRST;
                    n_phase = PH_VALUE;
                end
                PH_VALUE: begin
                    n_vacc = v_acc;
                    n_vst  = v_st;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_comb begin
        if (n_radix == RX_BIN && n_phase == PH_VALUE) begin
            res_ok = (n_vst != ST_BAD);
        end else begin
            res_ok = (n_phase != PH_BASE) && (n_vst == ST_DIGITS || n_vst == ST_STOPPED);
        end
        if (n_phase != PH_BEFORE && (n_wst == ST_DIGITS || n_wst == ST_STOPPED)) begin
            res_width = n_wacc;
        end else begin
            res_width = DEFAULT_WIDTH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_BEFORE;
            r_radix     <= RX_DEC;
            r_wacc      <= '0;
            r_wst       <= ST_FIRST;
            r_vacc      <= '0;
            r_vst       <= ST_FIRST;
            o_out_valid <= 1'b0;
            o_ok        <= 1'b0;
            o_value     <= '0;
            o_width     <= '0;
        end else begin
            if (pop && i_item.last) begin
                o_out_valid <= 1'b1;
                o_ok        <= res_ok;
                o_value     <= res_ok ? n_vacc : '0;
                o_width     <= res_ok ? res_width : '0;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if (pop) begin
                if (i_item.last) begin
                    r_phase <= PH_BEFORE;
                    r_radix <= RX_DEC;
                    r_wacc  <= '0;
                    r_wst   <= ST_FIRST;
                    r_vacc  <= '0;
                    r_vst   <= ST_FIRST;
                end else begin
                    r_phase <= n_phase;
                    r_radix <= n_radix;
                    r_wacc  <= n_wacc;
                    r_wst   <= n_wst;
                    r_vacc  <= n_vacc;
                    r_vst   <= n_vst;
                end
            end
        end
    end

endmodule

`default_nettype wire
